// ----- rtl/pecq_pkg.sv -----
// Package with types and constants of the priority evicting command queue.
package pecq_pkg;

  localparam int unsigned Depth = 4096;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [15:0] LimitReset = 16'd256;

  localparam logic [2:0] KindSetBlock = 3'd0;
  localparam logic [2:0] KindSpawn = 3'd1;
  localparam logic [2:0] KindDestroy = 3'd2;
  localparam logic [2:0] KindNetEvent = 3'd6;
  localparam logic [2:0] KindUnknown = 3'd7;

  localparam logic [2:0] StEnq = 3'd0;
  localparam logic [2:0] StUnknown = 3'd1;
  localparam logic [2:0] StDropped = 3'd2;
  localparam logic [2:0] StEvicted = 3'd3;
  localparam logic [2:0] StRejected = 3'd4;
  localparam logic [2:0] StPopped = 3'd5;
  localparam logic [2:0] StEmpty = 3'd6;

  localparam logic [1:0] ClsInRange = 2'd0;
  localparam logic [1:0] ClsDeferred = 2'd1;
  localparam logic [1:0] ClsInvalid = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POP_RD,
    S_POP_CLS,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]   kind;
    logic         crit;
    logic [127:0] args;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] raddr;
  } mem_ctl_t;

  function automatic logic is_critical(logic [2:0] kind, logic flag);
    return flag || kind == KindSetBlock || kind == KindSpawn ||
      kind == KindDestroy || kind == KindNetEvent;
  endfunction

endpackage

// ----- rtl/priority_evicting_command_queue.sv -----
// Top level of the priority evicting command queue.
// A bounded in-order queue of 4096 commands held in one single-port-read memory. An enqueue
// goes straight to its result and a pop first reads and classifies the oldest entry, each
// plus any output stall; an enqueue on a full queue with a critical command walks the memory
// from the newest entry back to the newest non-critical one (one read and test per entry), and
// then moves every newer entry down by one (one read and write per entry moved); if every entry
// is critical, the command is rejected instead. The memory's single read port sets this pace.
// One result is produced per accepted command; the next command is taken once it is out.
module priority_evicting_command_queue import pecq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         command_i,
  input  logic [2:0]   entry_kind_i,
  input  logic         critical_flag_i,
  input  logic signed [31:0] arg_a_i,
  input  logic signed [31:0] arg_b_i,
  input  logic signed [31:0] arg_c_i,
  input  logic signed [31:0] arg_d_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   status_o,
  output logic [2:0]   out_kind_o,
  output logic signed [31:0] out_a_o,
  output logic signed [31:0] out_b_o,
  output logic signed [31:0] out_c_o,
  output logic signed [31:0] out_d_o,
  output logic [1:0]   pop_class_o,
  output logic [12:0]  occupancy_o,
  output logic [63:0]  dropped_count_o,
  output logic [63:0]  rejected_count_o
);

  state_e state_q, state_d;
  logic [15:0] limit_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] rpos_q, rpos_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [63:0] drop_q, drop_d, rej_q, rej_d;
  entry_t new_q, new_d;
  logic [2:0] st_q, st_d;
  entry_t pe_q, pe_d;
  logic [1:0] cls_q, cls_d;
  mem_ctl_t ctl;
  entry_t wdata, rdata;
  logic full;

  pecq_store u_store (.clk_i(clk_i), .ctl_i(ctl), .wdata_i(wdata), .rdata_o(rdata));

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign full = (fill_q == FillW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= LimitReset;
      fill_q <= '0;
      rpos_q <= '0;
      drop_q <= '0;
      rej_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      rpos_q <= rpos_d;
      drop_q <= drop_d;
      rej_q <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
    st_q <= st_d;
    pe_q <= pe_d;
    cls_q <= cls_d;
  end

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    rpos_d = rpos_q;
    drop_d = drop_q;
    rej_d = rej_q;
    idx_d = idx_q;
    new_d = new_q;
    st_d = st_q;
    pe_d = pe_q;
    cls_d = cls_q;
    ctl.we = 1'b0;
    ctl.waddr = rpos_q + idx_q;
    ctl.raddr = rpos_q + idx_q;
    wdata = rdata;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pe_d = '0;
          cls_d = ClsInRange;
          new_d.kind = entry_kind_i;
          new_d.crit = is_critical(entry_kind_i, critical_flag_i);
          new_d.args = {arg_d_i, arg_c_i, arg_b_i, arg_a_i};
          state_d = S_OUT;
          if (command_i) begin
            if (fill_q == '0) begin
              st_d = StEmpty;
            end else begin
              st_d = StPopped;
              ctl.raddr = rpos_q;
              state_d = S_POP_RD;
            end
          end else if (entry_kind_i == KindUnknown) begin
            st_d = StUnknown;
          end else if (!full) begin
            st_d = StEnq;
            ctl.we = 1'b1;
            ctl.waddr = rpos_q + AddrW'(fill_q);
            wdata = new_d;
            fill_d = fill_q + 1'b1;
          end else if (!new_d.crit) begin
            st_d = StDropped;
            drop_d = drop_q + 1'b1;
          end else begin
            idx_d = AddrW'(fill_q - 1'b1);
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!rdata.crit) begin
          drop_d = drop_q + 1'b1;
          st_d = StEvicted;
          state_d = S_SHIFT_RD;
        end else if (idx_q == '0) begin
          rej_d = rej_q + 1'b1;
          st_d = StRejected;
          state_d = S_OUT;
        end else begin
          idx_d = idx_q - 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SHIFT_RD: begin
        if (FillW'(idx_q) + 1'b1 >= fill_q) begin
          ctl.we = 1'b1;
          wdata = new_q;
          state_d = S_OUT;
        end else begin
          ctl.raddr = rpos_q + idx_q + 1'b1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl.we = 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_POP_RD: begin
        ctl.raddr = rpos_q;
        state_d = S_POP_CLS;
      end
      S_POP_CLS: begin
        pe_d = rdata;
        pe_d.crit = 1'b0;
        if (rdata.kind == KindSetBlock) begin
          cls_d = (!rdata.args[127] && rdata.args[127:96] < {16'd0, limit_q}) ?
            ClsInRange : ClsInvalid;
        end else if (rdata.kind == KindUnknown) begin
          cls_d = ClsInvalid;
        end else begin
          cls_d = ClsDeferred;
        end
        rpos_d = rpos_q + 1'b1;
        fill_d = fill_q - 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign out_kind_o = pe_q.kind;
  assign out_a_o = pe_q.args[31:0];
  assign out_b_o = pe_q.args[63:32];
  assign out_c_o = pe_q.args[95:64];
  assign out_d_o = pe_q.args[127:96];
  assign pop_class_o = cls_q;
  assign occupancy_o = 13'(fill_q);
  assign dropped_count_o = drop_q;
  assign rejected_count_o = rej_q;

endmodule

// ----- rtl/pecq_store.sv -----
// Entry store of the command queue: one write port, one registered read port.
module pecq_store import pecq_pkg::*; (
  input  logic     clk_i,
  input  mem_ctl_t ctl_i,
  input  entry_t   wdata_i,
  output entry_t   rdata_o
);

  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= wdata_i;
    end
    rdata_o <= mem_q[ctl_i.raddr];
  end

endmodule

// ----- rtl/pecq_checker.sv -----
// Port-level checker for the priority evicting command queue, bound to the top level.
module pecq_checker import pecq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [1:0]  pop_class_o,
  input logic [12:0] occupancy_o
);

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while a result waits");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_o <= 13'(Depth)) else $error("occupancy beyond depth");

  a_cls_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StPopped |-> pop_class_o == ClsInRange)
    else $error("class set on a non-pop result");

  a_rej_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StRejected |-> occupancy_o == 13'(Depth))
    else $error("critical rejected while room remained");

endmodule

bind priority_evicting_command_queue pecq_checker u_pecq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
  .pop_class_o(pop_class_o), .occupancy_o(occupancy_o)
);
